// ===== rtl/crc_pkg.sv =====
`timescale 1ns / 1ps

package crc_pkg;

   // Width of every field on the request and response channels.
   localparam int FIELD_BITS = 32;

   // Status that the gcd engine reports back to the range sequencer.
   typedef struct packed {
      logic done;
      logic coprime;
   } gcd_stat_type;

endpackage

// ===== rtl/crc_if.sv =====
`timescale 1ns / 1ps

interface crc_req_if import crc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] range_start;
   logic [FIELD_BITS-1:0] range_stop;
   logic [FIELD_BITS-1:0] modulus;

   modport source (output valid, output range_start, output range_stop, output modulus,
                   input ready);
   modport sink (input valid, input range_start, input range_stop, input modulus,
                 output ready);
endinterface

interface crc_rsp_if import crc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] coprime_count;

   modport source (output valid, output coprime_count, input ready);
   modport sink (input valid, input coprime_count, output ready);
endinterface

// ===== rtl/crc_rem.sv =====
`timescale 1ns / 1ps

module crc_rem #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic [VALUE_BITS-1:0] rem_step;

   // One quotient bit per cycle: bring down the next dividend bit and
   // subtract the divisor when it fits.
   always_comb begin
      trial = {rem_ff, shift_ff[VALUE_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = diff[VALUE_BITS-1:0];
      end else begin
         rem_step = trial[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(VALUE_BITS);
         rem_in   = '0;
         shift_in = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_ff << 1;
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/crc_gcd.sv =====
`timescale 1ns / 1ps

module crc_gcd import crc_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] modulus,
   input  logic [VALUE_BITS-1:0] candidate,
   output gcd_stat_type          stat
);

   typedef enum logic [2:0] {
      GCD_IDLE   = 3'b001,
      GCD_CHECK  = 3'b010,
      GCD_DIVIDE = 3'b100
   } gcd_state_type;

   gcd_state_type         state_ff, state_in;
   logic                  done_ff, done_in;
   logic                  coprime_ff, coprime_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;

   logic                  rem_start;
   logic                  rem_done;
   logic [VALUE_BITS-1:0] rem_value;

   crc_rem #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (a_ff),
      .divisor   (b_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // Euclid: (a, b) becomes (b, a mod b) until b is zero; a is then the gcd.
   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      coprime_in = coprime_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      rem_start  = 1'b0;
      case (state_ff)
         GCD_IDLE: begin
            if (start) begin
               a_in     = modulus;
               b_in     = candidate;
               state_in = GCD_CHECK;
            end
         end
         GCD_CHECK: begin
            if (b_ff == '0) begin
               done_in    = 1'b1;
               coprime_in = (a_ff == VALUE_BITS'(1));
               state_in   = GCD_IDLE;
            end else begin
               rem_start = 1'b1;
               state_in  = GCD_DIVIDE;
            end
         end
         GCD_DIVIDE: begin
            if (rem_done) begin
               a_in     = b_ff;
               b_in     = rem_value;
               state_in = GCD_CHECK;
            end
         end
         default: begin
            state_in = GCD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GCD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      coprime_ff <= coprime_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
   end

   assign stat.done    = done_ff;
   assign stat.coprime = coprime_ff;

endmodule

// ===== rtl/coprime_range_counter.sv =====
`timescale 1ns / 1ps

// Counts the values x with range_start <= x < range_stop whose greatest
// common divisor with the modulus is 1, and returns one count per request
// item. Each candidate runs through Euclid's algorithm, and every remainder
// step is done by a bit-serial divider that retires one quotient bit per
// cycle. An empty range, a modulus of 0 and a modulus of 1 are answered
// directly. Requests are handled one at a time; a finished count waits in
// the output register while the next request is taken.
module coprime_range_counter import crc_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   crc_req_if.sink    req_chan,
   crc_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TEST   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } top_state_type;

   top_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in;
   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic [VALUE_BITS-1:0] mod_ff, mod_in;
   logic [VALUE_BITS-1:0] x_ff, x_in;
   logic [VALUE_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [VALUE_BITS-1:0] req_lo;
   logic [VALUE_BITS-1:0] req_hi;
   logic [VALUE_BITS-1:0] req_mod;
   logic [VALUE_BITS-1:0] x_next;
   logic                  accept;
   logic                  load_rsp;
   logic                  gcd_start;
   gcd_stat_type          gcd_stat;

   crc_gcd #(
      .VALUE_BITS (VALUE_BITS)
   ) u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .modulus   (mod_ff),
      .candidate (x_ff),
      .stat      (gcd_stat)
   );

   assign req_lo    = VALUE_BITS'(req_chan.range_start);
   assign req_hi    = VALUE_BITS'(req_chan.range_stop);
   assign req_mod   = VALUE_BITS'(req_chan.modulus);
   assign accept    = req_chan.valid && (state_ff == ST_IDLE);
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign gcd_start = (state_ff == ST_TEST);
   assign x_next    = x_ff + VALUE_BITS'(1);

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mod_in   = mod_ff;
      x_in     = x_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lo_in  = req_lo;
               hi_in  = req_hi;
               mod_in = req_mod;
               x_in   = req_lo;
               if (req_hi <= req_lo) begin
                  count_in = '0;
                  state_in = ST_FINISH;
               end else if (req_mod == '0) begin
                  // gcd(x, 0) = x, so only the value one can count.
                  count_in = VALUE_BITS'(req_lo <= VALUE_BITS'(1) &&
                                         VALUE_BITS'(1) < req_hi);
                  state_in = ST_FINISH;
               end else if (req_mod == VALUE_BITS'(1)) begin
                  count_in = req_hi - req_lo;
                  state_in = ST_FINISH;
               end else begin
                  count_in = '0;
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (gcd_stat.done) begin
               count_in = count_ff + VALUE_BITS'(gcd_stat.coprime);
               if (x_next == hi_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  x_in     = x_next;
                  state_in = ST_TEST;
               end
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = FIELD_BITS'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mod_ff       <= mod_in;
      x_ff         <= x_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.coprime_count = rsp_count_ff;

   // The running count covers only the candidates already tested.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (count_ff <= x_ff - lo_ff))
      else $error("coprime count exceeds the number of tested values");

   a_gcd_done_expected: assert property (@(posedge clock) disable iff (reset)
      gcd_stat.done |-> (state_ff == ST_WAIT))
      else $error("gcd engine finished while no candidate was outstanding");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_chan.valid && state_ff == ST_IDLE))
      else $error("finished count was not presented on the response channel");

endmodule
